@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the masked S-box block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/mdes_pkg.sv @@
// ----------------------------------------------------------------------------
// mdes_pkg
// Types, reset values, truth table ROM and table helpers for the masked
// DES S-box table recomputation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdes_pkg;

  localparam int TABLE_BITS = 64;
  localparam int ENTRY_W    = 6;
  localparam int SEL_W      = 3;
  localparam int OUT_W      = 4;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SCNT_W     = 4;

  localparam logic [SCNT_W-1:0] SHARE_COUNT_RST = 4'd2;
  localparam logic [WORD_W-1:0] SEED_X_RST      = 32'd123456789;
  localparam logic [WORD_W-1:0] SEED_Y_RST      = 32'd362436069;
  localparam logic [WORD_W-1:0] SEED_Z_RST      = 32'd521288629;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHARE_COUNT = 2'd0,
    REG_SEED_X      = 2'd1,
    REG_SEED_Y      = 2'd2,
    REG_SEED_Z      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_PERM,
    S_RND_HI,
    S_RND_LO,
    S_EXTRACT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [SEL_W-1:0]   sbox_select;
    logic [ENTRY_W-1:0] share_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_share;
    logic             last_share;
  } out_item_t;

  // Row {bit, sbox} holds the truth table of one output bit of one S-box.
  localparam logic [TABLE_BITS-1:0] TRUTH_ROM [32] = '{
    64'h1e2d81f66097de89, 64'hf168a61d4b5ac4b3, 64'h596aa695c639b1d2, 64'he71992c3583eed90,
    64'h129d6ed24b69b325, 64'h32c53c3e9a56c5a9, 64'h65969e929e69712c, 64'hd43e3986b38146f9,
    64'h94f8f906492b97e4, 64'hc3f929462ed1562e, 64'h92ed439c30699d6e, 64'h8e733496f1688b35,
    64'hd4ba0f49639cd0e3, 64'h5b6849b63c87d34a, 64'h2f81d279582fa956, 64'h30fc8f13e51a68e5,
    64'hbd641e92d8e1e30d, 64'h97c362c9683c9f16, 64'h529e2f64ac61569b, 64'he970532e318e96d3,
    64'h69d666898539da96, 64'h965967a86b1c9963, 64'hc3c26799669b3961, 64'h96a5569a8d69729c,
    64'h986e67615e92b961, 64'h9a65c39676986987, 64'hcb0939d696b49669, 64'h7c1a09b798e7c349,
    64'h712c879e56b3b942, 64'hda962593a96d522d, 64'h669b69341f86e349, 64'h9d68e31c24bd5e83
  };

  // Entry e of a table sits at bit TABLE_BITS-1-e.
  function automatic logic entry_bit(input logic [TABLE_BITS-1:0] t,
                                     input logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] pos;
    pos = ~e;
    return t[pos];
  endfunction

  // New entry i takes old entry i^x.
  function automatic logic [TABLE_BITS-1:0] permute_table(input logic [TABLE_BITS-1:0] t,
                                                          input logic [ENTRY_W-1:0] x);
    logic [TABLE_BITS-1:0] r;
    logic [ENTRY_W-1:0]    src;
    logic [ENTRY_W-1:0]    dst;
    for (int i = 0; i < TABLE_BITS; i++) begin
      dst    = ~ENTRY_W'(i);
      src    = ~(ENTRY_W'(i) ^ x);
      r[dst] = t[src];
    end
    return r;
  endfunction

endpackage

@@ hdl/masked_des_sbox_table_recompute.sv @@
// ----------------------------------------------------------------------------
// masked_des_sbox_table_recompute
// Collects share_count masked 6-bit input shares, one item per start pulse,
// and after the last one evaluates the selected DES S-box by table
// recomputation, one output bit at a time, with a single permute unit, a
// single xorshift96 step unit and a small sequencer. Per output bit the
// sequencer loads the table, then for each of the first n-1 input shares
// permutes the table shares (one table share a cycle) and refreshes them
// (two generator words per share pair), then samples the output bit from
// every table share; the n output shares then go out on consecutive
// cycles. Busy stays high throughout an evaluation, and items that only
// collect a share leave busy low. Results appear on out_data with
// out_valid for exactly one cycle each; the receiver cannot stall them.
// Configuration writes are taken while busy is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module masked_des_sbox_table_recompute #(
  parameter int MAX_SHARES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  mdes_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output mdes_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mdes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdes_pkg::WORD_W-1:0]      cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SHARES + 1);
  localparam int IDX_W  = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
  localparam int TD     = (MAX_SHARES > 1) ? MAX_SHARES - 1 : 1;
  localparam int TI_W   = (TD > 1) ? $clog2(TD) : 1;
  localparam int TB     = mdes_pkg::TABLE_BITS;
  localparam int EW     = mdes_pkg::ENTRY_W;
  localparam int WW     = mdes_pkg::WORD_W;

  mdes_pkg::state_t state_r, state_nxt;

  logic [mdes_pkg::SCNT_W-1:0] share_count_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [WW-1:0]               s0_r, s1_r, s2_r;

  logic [EW-1:0]               in_sh_r [MAX_SHARES];
  logic [TB-1:0]               t0_r;
  logic [TB-1:0]               tbl_r [TD];
  logic [mdes_pkg::OUT_W-1:0]  outsh_r [MAX_SHARES];
  logic [WW-1:0]               hi_r;
  logic [EW-1:0]               xl_r;
  logic [mdes_pkg::SEL_W-1:0]  sel_r;
  logic [IDX_W-1:0]            nm1_r;
  logic [IDX_W-1:0]            j_r;
  logic [IDX_W-1:0]            rnd_r;
  logic [1:0]                  bit_r;

  logic                        accept;
  logic                        cfg_we;
  logic [CNT_W-1:0]            n_eff;
  logic [CNT_W-1:0]            cnt_use;
  logic [CNT_W-1:0]            cnt_inc;
  logic                        final_item;
  logic [IDX_W-1:0]            jm1;
  logic [TI_W-1:0]             tidx;
  logic [TB-1:0]               tsrc;
  logic [TB-1:0]               tperm;
  logic [WW-1:0]               px;
  logic [WW-1:0]               pword;
  logic [TB-1:0]               mask;
  logic                        j_last;
  logic                        rnd_last;

  // --------------------------------------------------------------------------
  // Share bookkeeping
  // --------------------------------------------------------------------------
  always_comb begin
    if (share_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(share_count_r) > MAX_SHARES) begin
      n_eff = CNT_W'(MAX_SHARES);
    end else begin
      n_eff = CNT_W'(share_count_r);
    end
  end

  assign accept     = start && !busy;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign cnt_use    = (cnt_r >= n_eff) ? '0 : cnt_r;
  assign cnt_inc    = cnt_use + CNT_W'(1);
  assign final_item = (cnt_inc >= n_eff);

  // --------------------------------------------------------------------------
  // Shared units: table share select, permute, generator step
  // --------------------------------------------------------------------------
  assign jm1   = j_r - IDX_W'(1);
  assign tidx  = jm1[TI_W-1:0];
  assign tsrc  = (j_r == '0) ? t0_r : tbl_r[tidx];
  assign tperm = mdes_pkg::permute_table(tsrc, in_sh_r[rnd_r]);

  always_comb begin
    px    = s0_r ^ (s0_r << 16);
    px    = px ^ (px >> 5);
    px    = px ^ (px << 1);
    pword = px ^ s1_r ^ s2_r;
  end

  // The first generator word of a pair fills the upper half of the mask.
  assign mask     = {hi_r, pword};
  assign j_last   = (j_r == nm1_r);
  assign rnd_last = (rnd_r == nm1_r - IDX_W'(1));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdes_pkg::S_IDLE: begin
        if (accept && final_item) state_nxt = mdes_pkg::S_INIT;
      end
      mdes_pkg::S_INIT: begin
        state_nxt = (nm1_r == '0) ? mdes_pkg::S_EXTRACT : mdes_pkg::S_PERM;
      end
      mdes_pkg::S_PERM: begin
        if (j_last) state_nxt = mdes_pkg::S_RND_HI;
      end
      mdes_pkg::S_RND_HI: begin
        state_nxt = mdes_pkg::S_RND_LO;
      end
      mdes_pkg::S_RND_LO: begin
        if (!j_last) begin
          state_nxt = mdes_pkg::S_RND_HI;
        end else if (rnd_last) begin
          state_nxt = mdes_pkg::S_EXTRACT;
        end else begin
          state_nxt = mdes_pkg::S_PERM;
        end
      end
      mdes_pkg::S_EXTRACT: begin
        if (j_last) state_nxt = (bit_r == 2'd3) ? mdes_pkg::S_EMIT : mdes_pkg::S_INIT;
      end
      mdes_pkg::S_EMIT: begin
        if (j_last) state_nxt = mdes_pkg::S_IDLE;
      end
      default: state_nxt = mdes_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy                = (state_r != mdes_pkg::S_IDLE);
    cfg_ready           = (state_r == mdes_pkg::S_IDLE);
    out_valid           = (state_r == mdes_pkg::S_EMIT);
    out_data.out_share  = outsh_r[j_r];
    out_data.last_share = j_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdes_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Control counters and configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      share_count_r <= mdes_pkg::SHARE_COUNT_RST;
      cnt_r         <= '0;
      j_r           <= '0;
      rnd_r         <= '0;
      bit_r         <= '0;
      nm1_r         <= '0;
      s0_r          <= mdes_pkg::SEED_X_RST;
      s1_r          <= mdes_pkg::SEED_Y_RST;
      s2_r          <= mdes_pkg::SEED_Z_RST;
    end else begin
      if (accept) begin
        cnt_r <= final_item ? '0 : cnt_inc;
        if (final_item) begin
          nm1_r <= IDX_W'(n_eff - CNT_W'(1));
          bit_r <= '0;
        end
      end

      if (cfg_we) begin
        unique case (mdes_pkg::cfg_reg_t'(cfg_index))
          mdes_pkg::REG_SHARE_COUNT: begin
            share_count_r <= cfg_data[mdes_pkg::SCNT_W-1:0];
            cnt_r         <= '0;
          end
          mdes_pkg::REG_SEED_X: s0_r <= cfg_data;
          mdes_pkg::REG_SEED_Y: s1_r <= cfg_data;
          mdes_pkg::REG_SEED_Z: s2_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        mdes_pkg::S_INIT: begin
          j_r   <= '0;
          rnd_r <= '0;
        end
        mdes_pkg::S_PERM: begin
          j_r <= j_last ? IDX_W'(1) : j_r + IDX_W'(1);
        end
        mdes_pkg::S_RND_HI: begin
          s0_r <= s1_r;
          s1_r <= s2_r;
          s2_r <= pword;
        end
        mdes_pkg::S_RND_LO: begin
          s0_r <= s1_r;
          s1_r <= s2_r;
          s2_r <= pword;
          if (!j_last) begin
            j_r <= j_r + IDX_W'(1);
          end else begin
            j_r <= '0;
            if (!rnd_last) rnd_r <= rnd_r + IDX_W'(1);
          end
        end
        mdes_pkg::S_EXTRACT: begin
          j_r <= j_last ? '0 : j_r + IDX_W'(1);
          if (j_last) bit_r <= bit_r + 2'd1;
        end
        mdes_pkg::S_EMIT: begin
          j_r <= j_last ? '0 : j_r + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Table shares, input shares and output shares
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      in_sh_r[cnt_use[IDX_W-1:0]] <= in_data.share_value;
      if (final_item) begin
        xl_r  <= in_data.share_value;
        sel_r <= in_data.sbox_select;
      end
    end

    unique case (state_r)
      mdes_pkg::S_INIT: begin
        t0_r <= mdes_pkg::TRUTH_ROM[{bit_r, sel_r}];
        for (int k = 0; k < TD; k++) begin
          tbl_r[k] <= '0;
        end
      end
      mdes_pkg::S_PERM: begin
        if (j_r == '0) begin
          t0_r <= tperm;
        end else begin
          tbl_r[tidx] <= tperm;
        end
      end
      mdes_pkg::S_RND_HI: begin
        hi_r <= pword;
      end
      mdes_pkg::S_RND_LO: begin
        t0_r        <= t0_r ^ mask;
        tbl_r[tidx] <= tbl_r[tidx] ^ mask;
      end
      mdes_pkg::S_EXTRACT: begin
        outsh_r[j_r][bit_r] <= mdes_pkg::entry_bit(tsrc, xl_r);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Results only leave while an evaluation is in progress.
  `ASSERT_IMPL(a_emit_busy, clk, rst_n, out_valid, busy)
  // Output shares of one evaluation go out on back-to-back cycles.
  `ASSERT_NEXT(a_emit_run, clk, rst_n, out_valid && !out_data.last_share, out_valid)
  // After the final output share the block is free for the next item.
  `ASSERT_NEXT(a_emit_done, clk, rst_n, out_valid && out_data.last_share, !busy)
  // A refresh never pairs table share 0 with itself.
  `ASSERT_IMPL(a_rnd_partner, clk, rst_n, state_r == mdes_pkg::S_RND_LO, j_r != '0)

endmodule

@@ tb/tb_masked_des_sbox_table_recompute.sv @@
// ----------------------------------------------------------------------------
// tb_masked_des_sbox_table_recompute
// Self-checking bench for the masked DES S-box table recomputation block.
// Input share items are queued by a stimulus process and fed by a clocked
// driver. A behavioral copy of the block predicts every output share,
// including the xorshift96 refresh masks, and a clocked monitor compares each
// strobed result against the oldest prediction. The run sweeps share counts,
// generator seeds and sender idle ratios.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_masked_des_sbox_table_recompute;

  localparam int unsigned RUN_LIMIT = 400000;

  typedef enum int unsigned {
    SEED_KEEP,
    SEED_RANDOM,
    SEED_ZERO,
    SEED_ONES
  } seed_mode_t;

  // Truth tables, row 8*bit + sbox, entry e at bit 63-e.
  localparam bit [63:0] SBOX_TRUTH [32] = '{
    64'h1e2d81f66097de89, 64'hf168a61d4b5ac4b3, 64'h596aa695c639b1d2, 64'he71992c3583eed90,
    64'h129d6ed24b69b325, 64'h32c53c3e9a56c5a9, 64'h65969e929e69712c, 64'hd43e3986b38146f9,
    64'h94f8f906492b97e4, 64'hc3f929462ed1562e, 64'h92ed439c30699d6e, 64'h8e733496f1688b35,
    64'hd4ba0f49639cd0e3, 64'h5b6849b63c87d34a, 64'h2f81d279582fa956, 64'h30fc8f13e51a68e5,
    64'hbd641e92d8e1e30d, 64'h97c362c9683c9f16, 64'h529e2f64ac61569b, 64'he970532e318e96d3,
    64'h69d666898539da96, 64'h965967a86b1c9963, 64'hc3c26799669b3961, 64'h96a5569a8d69729c,
    64'h986e67615e92b961, 64'h9a65c39676986987, 64'hcb0939d696b49669, 64'h7c1a09b798e7c349,
    64'h712c879e56b3b942, 64'hda962593a96d522d, 64'h669b69341f86e349, 64'h9d68e31c24bd5e83
  };

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  mdes_pkg::in_item_t   in_data   = '0;
  logic                 out_valid;
  mdes_pkg::out_item_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [mdes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mdes_pkg::WORD_W-1:0]    cfg_data  = '0;

  masked_des_sbox_table_recompute u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block's configuration and state.
  bit [3:0]    share_count_reg = 4'd2;
  bit [31:0]   gen_state [3]   = '{32'd123456789, 32'd362436069, 32'd521288629};
  bit [5:0]    held_share [8];
  int unsigned held_count      = 0;

  mdes_pkg::in_item_t   share_items_q [$];
  mdes_pkg::out_item_t  pending_out_shares [$];

  int unsigned idle_pct        = 0;
  int unsigned items_queued    = 0;
  int unsigned items_sent      = 0;
  int unsigned shares_checked  = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned evals_by_size [9];

  function automatic int unsigned active_shares();
    int unsigned n;
    n = share_count_reg;
    if (n == 0) n = 1;
    if (n > 8) n = 8;
    return n;
  endfunction

  // Cycles one evaluation takes after its last item, per the block's sequencer.
  function automatic int unsigned eval_cycles(int unsigned n);
    return 4 * (1 + (n - 1) * (3 * n - 2) + n) + n;
  endfunction

  function automatic bit [31:0] xorshift_word();
    bit [31:0] v;
    v = gen_state[0];
    v ^= v << 16;
    v ^= v >> 5;
    v ^= v << 1;
    gen_state[0] = gen_state[1];
    gen_state[1] = gen_state[2];
    gen_state[2] = v ^ gen_state[0] ^ gen_state[1];
    return gen_state[2];
  endfunction

  function automatic bit [63:0] shuffle_table(bit [63:0] t, bit [5:0] x);
    bit [63:0] r;
    for (int i = 0; i < 64; i++) r[63 - i] = t[63 - (i ^ int'(x))];
    return r;
  endfunction

  function automatic void apply_reg(mdes_pkg::cfg_reg_t idx, bit [31:0] v);
    case (idx)
      mdes_pkg::REG_SHARE_COUNT: begin
        share_count_reg = v[3:0];
        held_count = 0;
      end
      mdes_pkg::REG_SEED_X: gen_state[0] = v;
      mdes_pkg::REG_SEED_Y: gen_state[1] = v;
      mdes_pkg::REG_SEED_Z: gen_state[2] = v;
      default: ;
    endcase
  endfunction

  task automatic predict_sbox(input mdes_pkg::in_item_t it);
    int unsigned         n;
    bit [5:0]            last_x;
    bit [63:0]           tab [8];
    bit [63:0]           mask;
    bit [3:0]            acc [8];
    mdes_pkg::out_item_t res;
    n = active_shares();
    if (held_count >= n) held_count = 0;
    held_share[held_count] = it.share_value;
    held_count++;
    if (held_count < n) return;
    held_count = 0;
    last_x = held_share[n - 1];
    for (int k = 0; k < 8; k++) acc[k] = '0;
    for (int b = 0; b < 4; b++) begin
      tab[0] = SBOX_TRUTH[8 * b + int'(it.sbox_select)];
      for (int j = 1; j < 8; j++) tab[j] = '0;
      // Every input share but the last moves the tables, then they are remasked.
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = 0; j < n; j++) tab[j] = shuffle_table(tab[j], held_share[i]);
        for (int j = 1; j < n; j++) begin
          mask[63:32] = xorshift_word();
          mask[31:0]  = xorshift_word();
          tab[0] ^= mask;
          tab[j] ^= mask;
        end
      end
      for (int k = 0; k < n; k++) acc[k][b] = tab[k][63 - int'(last_x)];
    end
    for (int k = 0; k < n; k++) begin
      res.out_share  = acc[k];
      res.last_share = (k == n - 1);
      pending_out_shares.push_back(res);
    end
    evals_by_size[n]++;
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Driver: holds an item on in_data until the block takes it.
  always @(posedge clk) begin : drive_items
    bit slot_free;
    if (rst_n) begin
      slot_free = !start || !busy;
      if (start && !busy) begin
        predict_sbox(in_data);
        items_sent++;
      end
      if (slot_free) begin
        if (share_items_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          start   <= 1'b1;
          in_data <= share_items_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    mdes_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_out_shares.size() == 0) begin
        report_mismatch($sformatf("unexpected output share %h last %b",
                                  out_data.out_share, out_data.last_share));
      end else begin
        want = pending_out_shares.pop_front();
        shares_checked++;
        if (out_data.out_share !== want.out_share)
          report_mismatch($sformatf("out_share %h, expected %h",
                                    out_data.out_share, want.out_share));
        if (out_data.last_share !== want.last_share)
          report_mismatch($sformatf("last_share %b, expected %b",
                                    out_data.last_share, want.last_share));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_item(bit [2:0] sel, bit [5:0] value);
    mdes_pkg::in_item_t it;
    it.sbox_select = sel;
    it.share_value = value;
    share_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(mdes_pkg::cfg_reg_t idx, bit [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is taken and every output share is in, then let
  // the block finish any evaluation still in progress.
  task automatic settle();
    int unsigned guard;
    while (items_sent != items_queued) @(posedge clk);
    guard = 0;
    while (pending_out_shares.size() != 0 && guard < 4 * eval_cycles(8)) begin
      @(posedge clk);
      guard++;
    end
    if (pending_out_shares.size() != 0) begin
      report_mismatch($sformatf("%0d output shares never arrived",
                                pending_out_shares.size()));
      pending_out_shares.delete();
    end
    repeat (eval_cycles(active_shares()) + 4) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned idle, bit set_count, bit [3:0] count,
                           seed_mode_t seed_mode);
    bit [31:0]   seed;
    int unsigned total;
    settle();
    if (set_count) write_reg(mdes_pkg::REG_SHARE_COUNT, {28'd0, count});
    if (seed_mode != SEED_KEEP) begin
      for (int r = int'(mdes_pkg::REG_SEED_X); r <= int'(mdes_pkg::REG_SEED_Z); r++) begin
        case (seed_mode)
          SEED_ZERO: seed = '0;
          SEED_ONES: seed = '1;
          default:   seed = $urandom();
        endcase
        write_reg(mdes_pkg::cfg_reg_t'(r), seed);
      end
    end
    idle_pct = idle;
    // Counts that are not a multiple of the share count leave a partial
    // evaluation for the next phase to drop or finish.
    total = $urandom_range(68, 52);
    repeat (total) queue_item(3'($urandom_range(7, 0)), 6'($urandom_range(63, 0)));
  endtask

  initial begin
    for (int i = 0; i < 9; i++) evals_by_size[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: two shares, default seeds, extreme share values.
    queue_item(3'd7, 6'd63);
    queue_item(3'd7, 6'd0);
    queue_item(3'd0, 6'd0);
    queue_item(3'd0, 6'd63);

    // Single share: unmasked lookup in every S-box.
    settle();
    write_reg(mdes_pkg::REG_SHARE_COUNT, 32'd1);
    queue_item(3'd0, 6'd0);
    queue_item(3'd1, 6'd63);
    queue_item(3'd2, 6'h2a);
    queue_item(3'd3, 6'h15);
    queue_item(3'd4, 6'd1);
    queue_item(3'd5, 6'd62);
    queue_item(3'd6, 6'd32);
    queue_item(3'd7, 6'd31);

    // A share count of zero behaves as one share.
    settle();
    write_reg(mdes_pkg::REG_SHARE_COUNT, 32'd0);
    queue_item(3'd3, 6'd63);
    queue_item(3'd5, 6'd0);

    // Partial evaluation dropped by a share count write, then a count above
    // the maximum, which saturates at eight shares.
    settle();
    write_reg(mdes_pkg::REG_SHARE_COUNT, 32'd3);
    queue_item(3'd1, 6'd5);
    queue_item(3'd2, 6'd9);
    settle();
    write_reg(mdes_pkg::REG_SHARE_COUNT, 32'd15);
    for (int i = 0; i < 7; i++) queue_item(3'(i), 6'(9 * i));
    queue_item(3'd6, 6'd63);

    run_phase(0,  1'b1, 4'd2,  SEED_RANDOM);
    run_phase(82, 1'b1, 4'd3,  SEED_KEEP);
    run_phase(23, 1'b0, 4'd3,  SEED_RANDOM);
    run_phase(0,  1'b1, 4'd8,  SEED_ZERO);
    run_phase(82, 1'b1, 4'd15, SEED_ONES);
    run_phase(23, 1'b1, 4'd1,  SEED_KEEP);
    run_phase(0,  1'b1, 4'($urandom_range(7, 4)), SEED_RANDOM);
    settle();

    $display("Covered %0d items and %0d output shares with seed reloads and idle mixes.",
             items_sent, shares_checked);
    $display("Evaluations at 1..8 shares: %0d %0d %0d %0d %0d %0d %0d %0d",
             evals_by_size[1], evals_by_size[2], evals_by_size[3], evals_by_size[4],
             evals_by_size[5], evals_by_size[6], evals_by_size[7], evals_by_size[8]);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
